[rtl/ckst_pkg.sv]
// Shared sizes and types of the coordinate-keyed source table.
`default_nettype none

package ckst_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int SLOT_W      = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
   localparam int COORD_W     = 32;
   localparam int KIND_W      = 8;
   localparam int RSP_SLOT_W  = 6;
   localparam int RSP_COUNT_W = 7;

   // Request codes carried on req_type.
   typedef enum logic [1:0] {
      REQ_ADD    = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_QUERY  = 2'd2,
      REQ_CLEAR  = 2'd3
   } req_code_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } key_type;

   // Scan token handed from cell to cell.
   typedef struct packed {
      logic              active;
      logic              hit;
      logic [SLOT_W-1:0] hit_slot;
      logic              free_found;
      logic [SLOT_W-1:0] free_slot;
   } token_type;

   // Table update broadcast to every cell.
   typedef struct packed {
      logic              add;
      logic              remove;
      logic              clear_all;
      logic [SLOT_W-1:0] slot;
   } wr_type;

endpackage

`default_nettype wire

[rtl/ckst_cell.sv]
// One table slot: key, kind and valid bit, plus one stage of the scan token.
`default_nettype none

module ckst_cell
   import ckst_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [SLOT_W-1:0] cell_index,
   input  key_type           key_in,
   input  logic [KIND_W-1:0] kind_in,
   input  wr_type            wr_in,
   input  token_type         tok_in,
   output token_type         tok_out
);

   logic              valid_ff, valid_in;
   key_type           key_ff;
   logic [KIND_W-1:0] kind_ff;
   logic              active_ff;
   logic              hit_ff, hit_in;
   logic [SLOT_W-1:0] hit_slot_ff, hit_slot_in;
   logic              free_ff, free_in;
   logic [SLOT_W-1:0] free_slot_ff, free_slot_in;
   logic              match;
   logic              sel;

   assign match = valid_ff && (key_ff == key_in);
   assign sel   = (wr_in.slot == cell_index);

   // Fold this slot into the token; the lowest slot seen first wins.
   always_comb begin
      hit_in       = tok_in.hit | match;
      hit_slot_in  = tok_in.hit ? tok_in.hit_slot : cell_index;
      free_in      = tok_in.free_found | !valid_ff;
      free_slot_in = tok_in.free_found ? tok_in.free_slot : cell_index;
   end

   always_comb begin
      priority if (wr_in.clear_all) begin
         valid_in = 1'b0;
      end else if (wr_in.add && sel) begin
         valid_in = 1'b1;
      end else if (wr_in.remove && sel) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         active_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         active_ff <= tok_in.active;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff       <= hit_in;
      hit_slot_ff  <= hit_slot_in;
      free_ff      <= free_in;
      free_slot_ff <= free_slot_in;
      if (wr_in.add && sel) begin
         key_ff  <= key_in;
         kind_ff <= kind_in;
      end
   end

   assign tok_out = '{active:     active_ff,
                      hit:        hit_ff,
                      hit_slot:   hit_slot_ff,
                      free_found: free_ff,
                      free_slot:  free_slot_ff};

endmodule

`default_nettype wire

[rtl/coordinate_keyed_source_table.sv]
// Top level of the coordinate-keyed source table: request control and the row of slot cells.
`default_nettype none

// A table of TABLE_DEPTH slots (64), each keyed by a signed x,y,z coordinate.
// Issue a request by raising start while busy is low; the request word is
// taken at that edge. Add, remove and query send a scan token down the row
// of slot cells, one cell per clock, gathering the matching slot and the
// lowest free slot; the table is updated when the token leaves the last cell.
// Such a request keeps busy high until its result strobe, so no new request
// is taken while its token is in the row. Clear skips the scan. The result
// is on the rsp_ ports for one cycle only, marked by rsp_strobe, and cannot
// be held off: capture it then. busy drops in the strobe cycle, so the next
// request may be issued there. rsp_valid_count is the count after the
// request; rsp_slot_index is the filled slot on a successful add and zero
// otherwise.

module coordinate_keyed_source_table
   import ckst_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_type,
   input  logic signed [COORD_W-1:0] req_key_x,
   input  logic signed [COORD_W-1:0] req_key_y,
   input  logic signed [COORD_W-1:0] req_key_z,
   input  logic [KIND_W-1:0]         req_entry_kind,
   output logic                      rsp_strobe,
   output logic                      rsp_success,
   output logic [RSP_SLOT_W-1:0]     rsp_slot_index,
   output logic [RSP_COUNT_W-1:0]    rsp_valid_count
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_CLEAR
   } state_type;

   state_type                state_ff, state_in;
   logic                     launch_ff, launch_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   req_code_type             req_ff;
   key_type                  key_ff;
   logic [KIND_W-1:0]        kind_ff;
   logic                     rsp_strobe_ff, rsp_strobe_in;
   logic                     rsp_success_ff, rsp_success_in;
   logic [RSP_SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [RSP_COUNT_W-1:0]   rsp_count_ff;

   req_code_type             req_code;
   logic                     accept;
   logic                     done;
   wr_type                   wr;
   token_type                launch_tok;
   token_type                last_tok;
   token_type                tok [TABLE_DEPTH];

   assign req_code = req_code_type'(req_type);
   assign busy     = (state_ff != S_IDLE);
   assign accept   = start && !busy;

   // Fresh token enters the first cell in the cycle after accept, once the key is held.
   assign launch_tok = '{active: launch_ff, hit: 1'b0, hit_slot: '0,
                         free_found: 1'b0, free_slot: '0};
   assign last_tok   = tok[TABLE_DEPTH-1];
   assign done       = (state_ff == S_SCAN) && last_tok.active;

   // Next state, table update and result.
   always_comb begin
      state_in       = state_ff;
      launch_in      = 1'b0;
      count_in       = count_ff;
      wr             = '0;
      rsp_strobe_in  = 1'b0;
      rsp_success_in = 1'b0;
      rsp_slot_in    = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_code == REQ_CLEAR) begin
                  state_in = S_CLEAR;
               end else begin
                  state_in  = S_SCAN;
                  launch_in = 1'b1;
               end
            end
         end
         S_SCAN: begin
            if (done) begin
               state_in      = S_IDLE;
               rsp_strobe_in = 1'b1;
               unique case (req_ff)
                  REQ_ADD: begin
                     // Store only a new key, and only if a slot is free.
                     if (!last_tok.hit && last_tok.free_found) begin
                        wr.add         = 1'b1;
                        wr.slot        = last_tok.free_slot;
                        rsp_success_in = 1'b1;
                        rsp_slot_in    = RSP_SLOT_W'(last_tok.free_slot);
                        count_in       = count_ff + COUNT_W'(1);
                     end
                  end
                  REQ_REMOVE: begin
                     if (last_tok.hit) begin
                        wr.remove      = 1'b1;
                        wr.slot        = last_tok.hit_slot;
                        rsp_success_in = 1'b1;
                        if (count_ff != '0) begin
                           count_in = count_ff - COUNT_W'(1);
                        end
                     end
                  end
                  REQ_QUERY: begin
                     rsp_success_in = last_tok.hit;
                  end
                  REQ_CLEAR: begin
                     // Clear never scans; nothing to do here.
                  end
               endcase
            end
         end
         S_CLEAR: begin
            state_in       = S_IDLE;
            wr.clear_all   = 1'b1;
            count_in       = '0;
            rsp_strobe_in  = 1'b1;
            rsp_success_in = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         launch_ff     <= 1'b0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         launch_ff      <= launch_in;
         count_ff       <= count_in;
         rsp_strobe_ff  <= rsp_strobe_in;
         rsp_success_ff <= rsp_success_in;
         rsp_slot_ff    <= rsp_slot_in;
         rsp_count_ff   <= RSP_COUNT_W'(count_in);
         // Hold the request word for the whole scan.
         if (accept) begin
            req_ff  <= req_code;
            key_ff  <= '{x: req_key_x, y: req_key_y, z: req_key_z};
            kind_ff <= req_entry_kind;
         end
      end
   end

   // Row of slot cells; the token advances one cell per clock.
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         ckst_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cell_index (SLOT_W'(i)),
            .key_in     (key_ff),
            .kind_in    (kind_ff),
            .wr_in      (wr),
            .tok_in     (launch_tok),
            .tok_out    (tok[i])
         );
      end else begin : g_body
         ckst_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cell_index (SLOT_W'(i)),
            .key_in     (key_ff),
            .kind_in    (kind_ff),
            .wr_in      (wr),
            .tok_in     (tok[i-1]),
            .tok_out    (tok[i])
         );
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_success     = rsp_success_ff;
   assign rsp_slot_index  = rsp_slot_ff;
   assign rsp_valid_count = rsp_count_ff;

`ifndef SYNTH
   // A result only appears once the block is free again.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // An accepted request always makes the block busy next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted request did not raise busy");

   // The token leaves the row only during a scan.
   a_token_scan: assert property (@(posedge clock) disable iff (reset)
      last_tok.active |-> (state_ff == S_SCAN))
      else $error("scan token outside a scan");

   // Live count never passes the table depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(TABLE_DEPTH))
      else $error("live count above table depth");
`endif

endmodule

`default_nettype wire
